@@ rtl/tmm_pkg.sv @@
// Package for the typed message mailbox: field widths, status and command codes,
// and the message, request and result structs. No dependencies.
package tmm_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TYPE_W  = 16;
    localparam int PARAM_W = 32;
    localparam int STAT_W  = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // Command codes
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // One stored message
    typedef struct packed {
        logic [PARAM_W-1:0] param_b;
        logic [PARAM_W-1:0] param_a;
        logic [TYPE_W-1:0]  msg_type;
    } t_msg;

    // One accepted input item
    typedef struct packed {
        logic               cmd;
        logic               match_any;
        t_msg               msg;
    } t_req;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        t_msg               msg;
    } t_result;

endpackage

@@ rtl/typed_message_mailbox_top.sv @@
// Top level of the typed message mailbox: stream ports, output register,
// controller and slot memory. Uses tmm_pkg, tmm_ctrl and tmm_slot_mem.
// A send tests one slot at a time in the ring scan until it finds a free slot or reaches
// the end pointer; a refused send goes straight to the result; a receive does one
// memory read and type compare per slot. One item is in work at a time; the next item
// is accepted only once the result is taken, so result stalls hold it off.
// Reset clears slot valid bits, pointers and count; slot contents are not cleared.
module typed_message_mailbox_top #(
    parameter int QUEUE_DEPTH = tmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,   // msg_type[15:0], match_any[16], param_a[48:17],
                                     // param_b[80:49], zero pad[87:81]
    input  logic [0:0]  i_s_tuser,   // cmd[0]
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // out_type[15:0], out_a[47:16], out_b[79:48]
    output logic [1:0]  o_m_tuser    // status[1:0]
);
    import tmm_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    t_req             req;
    t_result          res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_msg             mem_wdata;
    t_msg             mem_rdata;

    logic             r_out_valid;
    t_result          r_out;

    // Unpack input item
    assign req.cmd          = i_s_tuser[0];
    assign req.match_any    = i_s_tdata[16];
    assign req.msg.msg_type = i_s_tdata[15:0];
    assign req.msg.param_a  = i_s_tdata[48:17];
    assign req.msg.param_b  = i_s_tdata[80:49];

    tmm_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tmm_slot_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_tuser         = r_out.status;
    assign o_m_tdata[15:0]   = r_out.msg.msg_type;
    assign o_m_tdata[47:16]  = r_out.msg.param_a;
    assign o_m_tdata[79:48]  = r_out.msg.param_b;

endmodule

@@ rtl/tmm_slot_mem.sv @@
// Slot storage of the mailbox: one synchronous memory holding type and both
// parameters per slot, one write port, one registered read port. Uses tmm_pkg.
module tmm_slot_mem #(
    parameter int QUEUE_DEPTH = tmm_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  tmm_pkg::t_msg      i_wdata,
    input  logic [IDX_W-1:0]   i_raddr,
    output tmm_pkg::t_msg      o_rdata
);
    import tmm_pkg::*;

    t_msg r_mem [QUEUE_DEPTH];
    t_msg r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tmm_ctrl.sv @@
// Mailbox controller: slot valid bits, ring pointers, message count and the
// scan sequencer driving tmm_slot_mem. Uses tmm_pkg.
module tmm_ctrl #(
    parameter int QUEUE_DEPTH = tmm_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  tmm_pkg::t_req      i_req,
    // result side
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output tmm_pkg::t_result   o_res,
    // slot memory
    output logic               o_mem_we,
    output logic [IDX_W-1:0]   o_mem_waddr,
    output tmm_pkg::t_msg      o_mem_wdata,
    output logic [IDX_W-1:0]   o_mem_raddr,
    input  tmm_pkg::t_msg      i_mem_rdata
);
    import tmm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEND = 2'd1;
    localparam logic [1:0] S_RECV = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    logic [1:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_start, r_end;
    logic [CNT_W-1:0]       r_count;
    logic [QUEUE_DEPTH-1:0] r_valid;

    // per-item working registers
    logic [IDX_W-1:0]       r_idx;       // slot under test
    logic [IDX_W-1:0]       r_steps;     // slots already tested on receive
    logic [IDX_W-1:0]       r_hit_idx;
    logic                   r_append;
    logic                   r_cmd;
    logic                   r_any;
    t_msg                   r_req_msg;
    logic [STAT_W-1:0]      r_status;
    t_msg                   r_res_msg;

    logic                   accept;
    logic                   commit;
    logic                   recv_match;
    logic [IDX_W-1:0]       idx_nxt;

    assign accept     = i_req_valid && o_req_ready;
    assign commit     = (r_state == S_FIN) && i_res_ready;
    assign idx_nxt    = ring_next(r_idx);
    assign recv_match = r_valid[r_idx] &&
                        (r_any || (i_mem_rdata.msg_type == r_req_msg.msg_type));

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = '{status: r_status, msg: r_res_msg};

    // Memory: read address runs one slot ahead of the compare; write only at commit
    assign o_mem_raddr = (r_state == S_RECV) ? idx_nxt : r_start;
    assign o_mem_we    = commit && (r_cmd == CMD_SEND) && (r_status == ST_OK);
    assign o_mem_waddr = r_hit_idx;
    assign o_mem_wdata = r_req_msg;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == CMD_RECV) begin
                        n_state = S_RECV;
                    end else if (r_count >= FULL_CNT) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SEND;
                    end
                end
            end
            S_SEND: begin
                if ((r_idx == r_end) || !r_valid[r_idx]) begin
                    n_state = S_FIN;
                end
            end
            S_RECV: begin
                if (recv_match || (r_steps == LAST_IDX)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_end   <= '0;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (commit && (r_status == ST_OK)) begin
                if (r_cmd == CMD_SEND) begin
                    r_valid[r_hit_idx] <= 1'b1;
                    r_count            <= r_count + 1'b1;
                    if (r_append) begin
                        r_end <= ring_next(r_end);
                    end
                end else begin
                    r_valid[r_hit_idx] <= 1'b0;
                    if (r_hit_idx == r_start) begin
                        r_start <= ring_next(r_start);
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
            end
        end
    end

    // Item working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd     <= i_req.cmd;
                    r_any     <= i_req.match_any;
                    r_req_msg <= i_req.msg;
                    r_idx     <= r_start;
                    r_steps   <= '0;
                    r_res_msg <= '0;
                    r_append  <= 1'b0;
                    r_status  <= ((i_req.cmd == CMD_SEND) && (r_count >= FULL_CNT)) ?
                                 ST_FULL : ST_OK;
                end
            end
            S_SEND: begin
                if (r_idx == r_end) begin
                    r_hit_idx <= r_end;
                    r_append  <= 1'b1;
                end else if (!r_valid[r_idx]) begin
                    r_hit_idx <= r_idx;
                end else begin
                    r_idx <= idx_nxt;
                end
            end
            S_RECV: begin
                if (recv_match) begin
                    r_hit_idx <= r_idx;
                    r_res_msg <= i_mem_rdata;
                end else if (r_steps == LAST_IDX) begin
                    r_status <= ST_NOT_FOUND;
                end else begin
                    r_idx   <= idx_nxt;
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("message count above depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (r_status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("send refused while mailbox not full");

    a_recv_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (r_cmd == CMD_RECV) && (r_status == ST_OK)
        |-> r_valid[r_hit_idx])
        else $error("receive took an empty slot");

    a_send_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |=> r_valid[$past(r_hit_idx)])
        else $error("sent slot not marked valid");

    a_fin_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after result");

endmodule
